@@ hw/rtl/energy_meter_poll_sequencer_macros.svh @@
// Assertion macros shared by the energy meter poll sequencer RTL.
`ifndef ENERGY_METER_POLL_SEQUENCER_MACROS_SVH
`define ENERGY_METER_POLL_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EMPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// When cond holds, nxt must hold at the following edge.
`define EMPS_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define EMPS_ASSERT(lbl, clk, rst, prop, msg)
`define EMPS_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg)
`endif
`endif

@@ hw/rtl/empoll_pkg.sv @@
// Shared types, codes, constants and frame/decode helpers of the poll sequencer.
package empoll_pkg;

   // Field and state widths, depths and lengths
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned MAXF_W      = 6;
   localparam int unsigned FAIL_W      = 7;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned QTY_W       = 3;
   localparam int unsigned PHASE_W     = 2;
   localparam int unsigned VALUE_W     = 22;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned RCNT_W      = 5;
   localparam int unsigned STEP_W      = 5;
   localparam int unsigned PAY_DEPTH   = 12;
   localparam int unsigned PAY_IDX_W   = 4;
   localparam int unsigned FRAME_IDX_W = 4;
   localparam int unsigned FRAME_LEN   = 16;
   localparam int unsigned FIFO_DEPTH  = 2;

   // Positions of the first and last payload bytes within a response
   localparam logic [RCNT_W-1:0] PAY_BASE = 5'd14;
   localparam logic [RCNT_W-1:0] PAY_END  = 5'd25;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_PERIOD   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESP_TIMEOUT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FAILURES  = 2'd2;

   // Register reset values
   localparam logic [TICK_W-1:0] POLL_PERIOD_RST  = 16'd1000;
   localparam logic [TICK_W-1:0] RESP_TIMEOUT_RST = 16'd1000;
   localparam logic [MAXF_W-1:0] MAX_FAILURES_RST = 6'd15;

   // Request event kinds
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MEAS  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   // Quantities
   localparam logic [QTY_W-1:0] QTY_VOLTAGE  = 3'd0;
   localparam logic [QTY_W-1:0] QTY_CURRENT  = 3'd1;
   localparam logic [QTY_W-1:0] QTY_ACTIVE   = 3'd2;
   localparam logic [QTY_W-1:0] QTY_REACTIVE = 3'd3;
   localparam logic [QTY_W-1:0] QTY_APPARENT = 3'd4;
   localparam logic [QTY_W-1:0] QTY_PF       = 3'd5;

   // Job codes passed from front to back
   localparam logic [1:0] JOB_REQUEST = 2'd0;
   localparam logic [1:0] JOB_DECODE  = 2'd1;
   localparam logic [1:0] JOB_ERROR   = 2'd2;

   typedef logic [PAY_DEPTH-1:0][BYTE_W-1:0] payload_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [1:0]       code;
      logic [QTY_W-1:0] qty;
      payload_type      payload;
   } job_type;

   // Byte i of the read frame for quantity q
   function automatic logic [BYTE_W-1:0] frame_byte(input logic [QTY_W-1:0] q,
                                                    input logic [FRAME_IDX_W-1:0] i);
      logic [BYTE_W-1:0] b;
      case (i)
         4'd0, 4'd7: b = 8'h68;
         4'd8:       b = 8'h11;
         4'd9:       b = 8'h04;
         4'd10:      b = 8'h33;
         4'd11:      b = 8'h32;
         4'd12:      b = 8'h34 + {5'b0, q};
         4'd13:      b = 8'h35;
         4'd14:      b = 8'hAF + {5'b0, q};
         4'd15:      b = 8'h16;
         default:    b = 8'hAA;
      endcase
      return b;
   endfunction

   // Response length in bytes
   function automatic logic [RCNT_W-1:0] resp_len(input logic [QTY_W-1:0] q);
      logic [RCNT_W-1:0] n;
      case (q)
         QTY_VOLTAGE:  n = 5'd22;
         QTY_CURRENT:  n = 5'd25;
         QTY_PF:       n = 5'd24;
         default:      n = 5'd28;
      endcase
      return n;
   endfunction

   // Three-byte values for current and the powers, two bytes otherwise
   function automatic logic wide_value(input logic [QTY_W-1:0] q);
      return (q == QTY_CURRENT) || (q == QTY_ACTIVE) || (q == QTY_REACTIVE) ||
             (q == QTY_APPARENT);
   endfunction

   // Number of values in a response
   function automatic logic [2:0] val_count(input logic [QTY_W-1:0] q);
      return ((q == QTY_VOLTAGE) || (q == QTY_CURRENT)) ? 3'd3 : 3'd4;
   endfunction

   // Voltage and current start at phase A, the rest with the total
   function automatic logic [PHASE_W-1:0] first_phase(input logic [QTY_W-1:0] q);
      return ((q == QTY_VOLTAGE) || (q == QTY_CURRENT)) ? 2'd1 : 2'd0;
   endfunction

   // Byte with each nibble offset by 3, read as two decimal digits
   function automatic logic signed [8:0] digit_pair(input logic [BYTE_W-1:0] b);
      logic signed [8:0] hi;
      logic signed [8:0] lo;
      hi = $signed({5'b0, b[7:4]}) - 9'sd3;
      lo = $signed({5'b0, b[3:0]}) - 9'sd3;
      return hi * 9'sd10 + lo;
   endfunction

endpackage

@@ hw/rtl/empoll_front.sv @@
// Front end: registers, poll/timeout timing, response byte capture, job issue.
module empoll_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_op,
   input  logic [empoll_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                                 csr_write,
   input  logic [empoll_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [empoll_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                 job_push,
   output empoll_pkg::job_type                  job,
   input  logic                                 job_full
);
   import empoll_pkg::*;

   logic [TICK_W-1:0] poll_period_ff;
   logic [TICK_W-1:0] resp_timeout_ff;
   logic [MAXF_W-1:0] max_failures_ff;

   logic              poll_mode_ff, poll_mode_in;
   logic [QTY_W-1:0]  qty_ff, qty_in;
   logic [RCNT_W-1:0] rcount_ff, rcount_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [FAIL_W-1:0] fail_ff, fail_in;
   payload_type       store_ff;

   logic                 accept;
   logic [TICK_W:0]      tick_next;
   logic [RCNT_W-1:0]    rcount_next;
   logic                 store_wr;
   logic [RCNT_W-1:0]    store_off;
   logic [PAY_IDX_W-1:0] store_idx;
   payload_type          store_merged;

   // Front stalls only while the job queue is full
   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_period_ff  <= POLL_PERIOD_RST;
         resp_timeout_ff <= RESP_TIMEOUT_RST;
         max_failures_ff <= MAX_FAILURES_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POLL_PERIOD:  poll_period_ff  <= csr_data;
            CSR_RESP_TIMEOUT: resp_timeout_ff <= csr_data;
            CSR_MAX_FAILURES: max_failures_ff <= csr_data[MAXF_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload capture for bytes 14 to 25 of the response
   assign tick_next   = {1'b0, tick_ff} + 17'd1;
   assign rcount_next = rcount_ff + 5'd1;
   assign store_wr    = accept && (req_op == OP_BYTE) && poll_mode_ff &&
                        (rcount_ff inside {[PAY_BASE:PAY_END]});
   assign store_off   = rcount_ff - PAY_BASE;
   assign store_idx   = store_off[PAY_IDX_W-1:0];

   always_comb begin
      store_merged = store_ff;
      if (store_wr) begin
         store_merged[store_idx] = req_rx_byte;
      end
   end

   // Next state and job issue
   always_comb begin
      poll_mode_in = poll_mode_ff;
      qty_in       = qty_ff;
      rcount_in    = rcount_ff;
      tick_in      = tick_ff;
      fail_in      = fail_ff;
      job_push     = 1'b0;
      job.code     = JOB_REQUEST;
      job.qty      = qty_ff;
      job.payload  = store_merged;
      if (accept) begin
         if (req_op == OP_TICK) begin
            if (!poll_mode_ff) begin
               if (tick_next >= {1'b0, poll_period_ff}) begin
                  poll_mode_in = 1'b1;
                  qty_in       = QTY_VOLTAGE;
                  rcount_in    = '0;
                  tick_in      = '0;
                  job_push     = 1'b1;
                  job.qty      = QTY_VOLTAGE;
               end else begin
                  tick_in = tick_next[TICK_W-1:0];
               end
            end else if (tick_next >= {1'b0, resp_timeout_ff}) begin
               tick_in  = '0;
               job_push = 1'b1;
               if (fail_ff > {1'b0, max_failures_ff}) begin
                  job.code = JOB_ERROR;
               end else begin
                  fail_in   = fail_ff + 7'd1;
                  rcount_in = '0;
               end
            end else begin
               tick_in = tick_next[TICK_W-1:0];
            end
         end else if (poll_mode_ff) begin
            if (rcount_next >= resp_len(qty_ff)) begin
               job_push  = 1'b1;
               job.code  = JOB_DECODE;
               fail_in   = '0;
               rcount_in = '0;
               tick_in   = '0;
               if (qty_ff != QTY_PF) begin
                  qty_in = qty_ff + 3'd1;
               end else begin
                  poll_mode_in = 1'b0;
                  qty_in       = QTY_VOLTAGE;
               end
            end else begin
               rcount_in = rcount_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_mode_ff <= 1'b0;
         qty_ff       <= QTY_VOLTAGE;
         rcount_ff    <= '0;
         tick_ff      <= '0;
         fail_ff      <= '0;
      end else begin
         poll_mode_ff <= poll_mode_in;
         qty_ff       <= qty_in;
         rcount_ff    <= rcount_in;
         tick_ff      <= tick_in;
         fail_ff      <= fail_in;
      end
   end

   // Payload store has no reset; every entry is written before it is decoded
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[store_idx] <= req_rx_byte;
      end
   end

endmodule

@@ hw/rtl/empoll_fifo.sv @@
// Short job queue between the front end and the response generator.
`include "energy_meter_poll_sequencer_macros.svh"
module empoll_fifo #(
   parameter int unsigned DEPTH = empoll_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  empoll_pkg::job_type push_data,
   output logic                full,
   input  logic                pop,
   output empoll_pkg::job_type pop_data,
   output logic                empty
);
   import empoll_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   job_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EMPS_ASSERT(a_no_overflow, clock, reset, !(push && full), "job queue overflow")
   `EMPS_ASSERT(a_no_underflow, clock, reset, !(pop && empty), "job queue underflow")
   `EMPS_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "bad queue count")
   `EMPS_ASSERT_NEXT(a_push_visible, clock, reset, push && !pop, !empty, "pushed job lost")

endmodule

@@ hw/rtl/empoll_back.sv @@
// Back end: expands jobs into frame bytes, measurements and errors.
`include "energy_meter_poll_sequencer_macros.svh"
module empoll_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_avail,
   input  empoll_pkg::job_type                 job_in,
   output logic                                job_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [empoll_pkg::KIND_W-1:0]       rsp_kind,
   output logic [empoll_pkg::BYTE_W-1:0]       rsp_tx_byte,
   output logic [empoll_pkg::QTY_W-1:0]        rsp_quantity,
   output logic [empoll_pkg::PHASE_W-1:0]      rsp_phase,
   output logic signed [empoll_pkg::VALUE_W-1:0] rsp_value,
   output logic                                rsp_last
);
   import empoll_pkg::*;

   logic              cur_valid_ff, cur_valid_in;
   job_type           cur_ff, cur_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] tx_ff, tx_in;
   logic [QTY_W-1:0]  qty_ff, qty_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   value_type         value_ff, value_in;
   logic              last_ff, last_in;

   logic              slot_free;
   logic              emit;
   logic [2:0]        nmeas;
   logic              wide;
   logic              is_meas;
   logic [STEP_W-1:0] total;
   logic              is_last;
   logic [STEP_W-1:0] step_rel;
   logic [QTY_W-1:0]  qty_next;
   value_type         d0, d1, d2;
   value_type         meas_value;

   // Output slot frees when empty or taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && slot_free;

   // Job shape
   assign nmeas    = val_count(cur_ff.qty);
   assign wide     = wide_value(cur_ff.qty);
   assign qty_next = cur_ff.qty + 3'd1;
   assign is_meas  = (cur_ff.code == JOB_DECODE) && (step_ff < {2'b0, nmeas});
   assign step_rel = step_ff - {2'b0, nmeas};

   always_comb begin
      case (cur_ff.code)
         JOB_REQUEST: total = 5'(FRAME_LEN);
         JOB_DECODE:  total = {2'b0, nmeas} +
                              ((cur_ff.qty != QTY_PF) ? 5'(FRAME_LEN) : 5'd0);
         default:     total = 5'd1;
      endcase
   end
   assign is_last = (step_ff == total - 5'd1);

   // Value from the low bytes of the shifting payload, low byte first
   assign d0 = value_type'(digit_pair(cur_ff.payload[0]));
   assign d1 = value_type'(digit_pair(cur_ff.payload[1]));
   assign d2 = value_type'(digit_pair(cur_ff.payload[2]));
   assign meas_value = wide ? (d2 * 22'sd10000 + d1 * 22'sd100 + d0)
                            : (d1 * 22'sd100 + d0);

   // Take a new job as the current one finishes
   assign job_pop = job_avail && (!cur_valid_ff || (emit && is_last));

   // Result selection and sequencing
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      tx_in        = tx_ff;
      qty_in       = qty_ff;
      phase_in     = phase_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = KIND_TX;
         tx_in        = '0;
         qty_in       = cur_ff.qty;
         phase_in     = '0;
         value_in     = '0;
         last_in      = is_last;
         case (cur_ff.code)
            JOB_REQUEST: begin
               tx_in = frame_byte(cur_ff.qty, step_ff[FRAME_IDX_W-1:0]);
            end
            JOB_DECODE: begin
               if (is_meas) begin
                  kind_in  = KIND_MEAS;
                  phase_in = first_phase(cur_ff.qty) + step_ff[PHASE_W-1:0];
                  value_in = meas_value;
                  cur_in.payload = wide ? (cur_ff.payload >> (3 * BYTE_W))
                                        : (cur_ff.payload >> (2 * BYTE_W));
               end else begin
                  qty_in = qty_next;
                  tx_in  = frame_byte(qty_next, step_rel[FRAME_IDX_W-1:0]);
               end
            end
            default: begin
               kind_in = KIND_ERROR;
            end
         endcase
         step_in = step_ff + 5'd1;
         if (is_last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (job_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = job_in;
         step_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      kind_ff  <= kind_in;
      tx_ff    <= tx_in;
      qty_ff   <= qty_in;
      phase_ff <= phase_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_tx_byte  = tx_ff;
   assign rsp_quantity = qty_ff;
   assign rsp_phase    = phase_ff;
   assign rsp_value    = value_ff;
   assign rsp_last     = last_ff;

   `EMPS_ASSERT(a_step_in_job, clock, reset, !cur_valid_ff || (step_ff < total), "step past job")
   `EMPS_ASSERT(a_pop_when_free, clock, reset, !job_pop || !cur_valid_ff || (emit && is_last), "job overrun")
   `EMPS_ASSERT(a_error_is_last, clock, reset, !(rsp_valid_ff && (kind_ff == KIND_ERROR)) || last_ff, "error not last")
   `EMPS_ASSERT_NEXT(a_job_continues, clock, reset, emit && !is_last, cur_valid_ff, "job dropped")

endmodule

@@ hw/rtl/energy_meter_poll_sequencer.sv @@
// Top level of the energy meter poll sequencer: front end, job queue, back end.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_op, req_rx_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_kind, rsp_tx_byte, rsp_quantity,
//                                            rsp_phase, rsp_value, rsp_last
//   csr      in         csr_write            csr_index, csr_data
//
// A request is taken every cycle while the job queue has room. The back end
// emits one response per cycle while rsp_stall is low; a request causes none,
// 1 for an error, 4 for power factor, 16 for a frame, or 19 or 20 for a decoded
// response followed by the next frame; the back end sets the rate.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// rsp_stall holds the output register and, once the queue fills, raises req_stall.
module energy_meter_poll_sequencer #(
   parameter int unsigned QUEUE_DEPTH = empoll_pkg::FIFO_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [empoll_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [empoll_pkg::KIND_W-1:0]         rsp_kind,
   output logic [empoll_pkg::BYTE_W-1:0]         rsp_tx_byte,
   output logic [empoll_pkg::QTY_W-1:0]          rsp_quantity,
   output logic [empoll_pkg::PHASE_W-1:0]        rsp_phase,
   output logic signed [empoll_pkg::VALUE_W-1:0] rsp_value,
   output logic                                  rsp_last,
   input  logic                                  csr_write,
   input  logic [empoll_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [empoll_pkg::CSR_DATA_W-1:0]     csr_data
);
   import empoll_pkg::*;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type pop_job;
   logic    queue_empty;

   // Timing and capture
   empoll_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .job_push    (push),
      .job         (push_job),
      .job_full    (queue_full)
   );

   // Decoupling queue
   empoll_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (queue_empty)
   );

   // Response generation
   empoll_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_avail    (!queue_empty),
      .job_in       (pop_job),
      .job_pop      (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_quantity (rsp_quantity),
      .rsp_phase    (rsp_phase),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last)
   );

endmodule

@@ sim/meter_poll_checker.sv @@
// Checker for the energy meter poll sequencer: predicts each response and compares.
module meter_poll_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [empoll_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [empoll_pkg::KIND_W-1:0]         rsp_kind,
   input  logic [empoll_pkg::BYTE_W-1:0]         rsp_tx_byte,
   input  logic [empoll_pkg::QTY_W-1:0]          rsp_quantity,
   input  logic [empoll_pkg::PHASE_W-1:0]        rsp_phase,
   input  logic signed [empoll_pkg::VALUE_W-1:0] rsp_value,
   input  logic                                  rsp_last,
   input  logic                                  csr_write,
   input  logic [empoll_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [empoll_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                    mismatches,
   output int                                    results_due,
   output logic                                  awaiting_reply,
   output logic [empoll_pkg::RCNT_W-1:0]         bytes_in
);
   timeunit 1ns;
   timeprecision 1ps;
   import empoll_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  tx_byte;
      logic [QTY_W-1:0]   quantity;
      logic [PHASE_W-1:0] phase;
      logic [VALUE_W-1:0] value;
      logic               last;
   } meter_result_type;

   // Predicted sequencer state and register copies
   logic                awaiting;
   logic [QTY_W-1:0]    qty_idx;
   logic [RCNT_W-1:0]   rx_count;
   logic [BYTE_W-1:0]   payload [0:PAY_DEPTH-1];
   logic [TICK_W-1:0]   ticks;
   logic [FAIL_W-1:0]   fails;
   logic [TICK_W-1:0]   period_cfg;
   logic [TICK_W-1:0]   timeout_cfg;
   logic [MAXF_W-1:0]   fail_limit_cfg;

   // Responses caused by one request, then the queue of all outstanding ones
   meter_result_type burst [0:19];
   int               burst_len;
   meter_result_type due_results [$];

   // Byte i of the read frame for quantity q
   function automatic logic [BYTE_W-1:0] request_octet(input logic [QTY_W-1:0] q,
                                                       input int i);
      case (i)
         0, 7:    return 8'h68;
         8:       return 8'h11;
         9:       return 8'h04;
         10:      return 8'h33;
         11:      return 8'h32;
         12:      return 8'h34 + BYTE_W'(q);
         13:      return 8'h35;
         14:      return 8'hAF + BYTE_W'(q);
         15:      return 8'h16;
         default: return 8'hAA;
      endcase
   endfunction

   function automatic int reply_length(input logic [QTY_W-1:0] q);
      case (q)
         QTY_VOLTAGE: return 22;
         QTY_CURRENT: return 25;
         QTY_PF:      return 24;
         default:     return 28;
      endcase
   endfunction

   // Each nibble carries a +3 offset; the byte reads as two decimal digits
   function automatic int bcd_offset_pair(input logic [BYTE_W-1:0] b);
      int hi;
      int lo;
      hi = int'(b[7:4]);
      lo = int'(b[3:0]);
      return 10 * (hi - 3) + (lo - 3);
   endfunction

   task automatic emit(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] tx,
                       input logic [QTY_W-1:0] q, input logic [PHASE_W-1:0] ph,
                       input int v);
      meter_result_type r;
      r.kind     = kind;
      r.tx_byte  = tx;
      r.quantity = q;
      r.phase    = ph;
      r.value    = v[VALUE_W-1:0];
      r.last     = 1'b0;
      burst[burst_len] = r;
      burst_len++;
   endtask

   task automatic send_poll_frame();
      for (int i = 0; i < FRAME_LEN; i++) begin
         emit(KIND_TX, request_octet(qty_idx, i), qty_idx, 2'd0, 0);
      end
      rx_count = '0;
      ticks    = '0;
   endtask

   // Values are stored low byte first; voltage and current have no total
   task automatic decode_reply(input logic [QTY_W-1:0] q);
      int w;
      int n;
      int first;
      int v;
      int pos;
      w     = (q == QTY_VOLTAGE || q == QTY_PF) ? 2 : 3;
      n     = (q == QTY_VOLTAGE || q == QTY_CURRENT) ? 3 : 4;
      first = (q == QTY_VOLTAGE || q == QTY_CURRENT) ? 1 : 0;
      for (int k = 0; k < n; k++) begin
         v = 0;
         for (int j = w; j > 0; j--) begin
            pos = k * w + j - 1;
            v = v * 100 + bcd_offset_pair(payload[PAY_IDX_W'(pos)]);
         end
         emit(KIND_MEAS, 8'h00, q, PHASE_W'(first + k), v);
      end
   endtask

   // Next state and responses for one accepted request
   task automatic advance_poll_state(input logic op, input logic [BYTE_W-1:0] b);
      logic [TICK_W:0]   t;
      logic [QTY_W-1:0]  q;
      logic [RCNT_W-1:0] off;
      meter_result_type  r;
      burst_len = 0;
      if (qty_idx > QTY_PF) qty_idx = QTY_VOLTAGE;
      if (op == OP_TICK) begin
         t = {1'b0, ticks} + 1'b1;
         if (!awaiting) begin
            if (t >= {1'b0, period_cfg}) begin
               awaiting = 1'b1;
               qty_idx  = QTY_VOLTAGE;
               send_poll_frame();
            end else begin
               ticks = t[TICK_W-1:0];
            end
         end else if (t >= {1'b0, timeout_cfg}) begin
            // past the limit: report the error and restart the timeout only
            if (fails > {1'b0, fail_limit_cfg}) begin
               emit(KIND_ERROR, 8'h00, qty_idx, 2'd0, 0);
               ticks = '0;
            end else begin
               fails = fails + 1'b1;
               send_poll_frame();
            end
         end else begin
            ticks = t[TICK_W-1:0];
         end
      end else if (awaiting) begin
         q   = qty_idx;
         off = rx_count - PAY_BASE;
         if (rx_count >= PAY_BASE && rx_count <= PAY_END) payload[off[PAY_IDX_W-1:0]] = b;
         rx_count = rx_count + 1'b1;
         if (rx_count >= reply_length(q)) begin
            decode_reply(q);
            fails    = '0;
            rx_count = '0;
            if (q < QTY_PF) begin
               qty_idx = q + 1'b1;
               send_poll_frame();
            end else begin
               awaiting = 1'b0;
               qty_idx  = QTY_VOLTAGE;
               ticks    = '0;
            end
         end
      end
      for (int i = 0; i < burst_len; i++) begin
         r      = burst[i];
         r.last = (i == burst_len - 1);
         due_results.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_response();
      meter_result_type want;
      if (due_results.size() == 0) begin
         $display("%0t: response expected none actual kind %0d tx_byte %0d value %0d",
                  $time, rsp_kind, rsp_tx_byte, rsp_value);
         mismatches++;
      end else begin
         want = due_results.pop_front();
         compare_field("kind", want.kind, rsp_kind);
         compare_field("tx_byte", want.tx_byte, rsp_tx_byte);
         compare_field("quantity", want.quantity, rsp_quantity);
         compare_field("phase", want.phase, rsp_phase);
         compare_field("value", $signed(want.value), rsp_value);
         compare_field("last", want.last, rsp_last);
      end
   endtask

   // Responses are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (reset) begin
         awaiting       = 1'b0;
         qty_idx        = QTY_VOLTAGE;
         rx_count       = '0;
         ticks          = '0;
         fails          = '0;
         period_cfg     = POLL_PERIOD_RST;
         timeout_cfg    = RESP_TIMEOUT_RST;
         fail_limit_cfg = MAX_FAILURES_RST;
         for (int i = 0; i < PAY_DEPTH; i++) payload[i] = '0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_response();
         if (csr_write) begin
            case (csr_index)
               CSR_POLL_PERIOD:  period_cfg     = csr_data;
               CSR_RESP_TIMEOUT: timeout_cfg    = csr_data;
               CSR_MAX_FAILURES: fail_limit_cfg = csr_data[MAXF_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) advance_poll_state(req_op, req_rx_byte);
      end
      results_due    <= due_results.size();
      awaiting_reply <= awaiting;
      bytes_in       <= rx_count;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the poll sequencer testbench: clock, reset, register setup, requests and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import empoll_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT      = 1500000;
   localparam int unsigned SETTLE_CYCLES    = 40;
   localparam int unsigned LONG_HOLD_CYCLES = 400;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_op;
   logic [BYTE_W-1:0]          req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [KIND_W-1:0]          rsp_kind;
   logic [BYTE_W-1:0]          rsp_tx_byte;
   logic [QTY_W-1:0]           rsp_quantity;
   logic [PHASE_W-1:0]         rsp_phase;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic                       rsp_last;
   logic                       csr_write;
   logic [CSR_INDEX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]      csr_data;
   int                         mismatches;
   int                         results_due;
   logic                       awaiting_reply;
   logic [RCNT_W-1:0]          bytes_in;

   int          tx_gap_pct;
   int          rx_gap_pct;
   bit          long_hold_req;
   bit          long_hold_done;
   int unsigned cycle_count = 0;

   energy_meter_poll_sequencer dut (.*);

   meter_poll_checker poll_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Response side: short random stalls, and one long hold on request
   initial begin
      rsp_stall      = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_gap_pct != 0 && $urandom_range(0, 99) < rx_gap_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until accepted
   task automatic offer(input logic op, input logic [BYTE_W-1:0] b);
      if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every predicted response is out and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all registers, plus the unused index, which must be ignored
   task automatic program_regs(input logic [TICK_W-1:0] period,
                               input logic [TICK_W-1:0] timeout,
                               input logic [MAXF_W-1:0] limit);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write <= 1'b1;
      csr_index <= CSR_POLL_PERIOD;
      csr_data  <= period;
      @(posedge clock);
      csr_index <= CSR_RESP_TIMEOUT;
      csr_data  <= timeout;
      @(posedge clock);
      csr_index <= CSR_MAX_FAILURES;
      csr_data  <= {junk[CSR_DATA_W-1:MAXF_W], limit};
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_data  <= ~junk;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Meter reply byte: payload positions mostly carry valid offset digits
   function automatic logic [BYTE_W-1:0] reply_byte(input logic [RCNT_W-1:0] pos);
      logic [BYTE_W-1:0] b;
      logic [3:0]        hi;
      logic [3:0]        lo;
      b = BYTE_W'($urandom);
      if (pos >= PAY_BASE && pos <= PAY_END) begin
         case ($urandom_range(0, 7))
            0: begin
               case ($urandom_range(0, 3))
                  0:       b = 8'h00;
                  1:       b = 8'hFF;
                  2:       b = 8'h33;
                  default: b = 8'hCC;
               endcase
            end
            1: ;
            default: begin
               hi = 4'($urandom_range(3, 12));
               lo = 4'($urandom_range(3, 12));
               b  = {hi, lo};
            end
         endcase
      end
      return b;
   endfunction

   // Ticks while idle, reply bytes or ticks while a response is due; noise bytes don't count
   task automatic run_phase(input int count, input int tick_pct, input int noise_pct);
      int          issued;
      logic [BYTE_W-1:0] b;
      issued = 0;
      while (issued < count) begin
         b = BYTE_W'($urandom);
         if (!awaiting_reply) begin
            if ($urandom_range(0, 99) < noise_pct) begin
               offer(OP_BYTE, b);
            end else begin
               offer(OP_TICK, b);
               issued++;
            end
         end else if ($urandom_range(0, 99) < tick_pct) begin
            offer(OP_TICK, b);
            issued++;
         end else begin
            offer(OP_BYTE, reply_byte(bytes_in));
            issued++;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_TICK;
      req_rx_byte   = '0;
      csr_write     = 1'b0;
      csr_index     = CSR_POLL_PERIOD;
      csr_data      = '0;
      tx_gap_pct    = 25;
      rx_gap_pct    = 10;
      long_hold_req = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: a byte while waiting is dropped, a tick just counts
      offer(OP_BYTE, 8'hFF);
      offer(OP_TICK, 8'h00);

      // Zero period fires on the next tick; one resend, then errors
      settle();
      program_regs(16'd0, 16'd2, 6'd0);
      offer(OP_BYTE, 8'h00);
      offer(OP_TICK, 8'hFF);
      offer(OP_BYTE, 8'h5A);
      offer(OP_TICK, 8'h00);
      offer(OP_TICK, 8'h00);
      offer(OP_TICK, 8'h00);
      offer(OP_TICK, 8'h00);
      offer(OP_TICK, 8'h00);
      offer(OP_TICK, 8'h00);

      // Zero timeout: the tick after the frame times out and resends it
      settle();
      program_regs(16'd1, 16'd0, 6'd1);
      offer(OP_TICK, 8'hA5);
      offer(OP_TICK, 8'h5A);

      // Full sweeps with rare ticks
      settle();
      program_regs(16'd3, 16'd40, 6'd15);
      run_phase(80, 3, 10);

      // Shortest timeout with the highest limit: long failure runs
      settle();
      program_regs(16'd1, 16'd1, 6'd63);
      run_phase(60, 60, 10);

      // Longer period and timeout at full rate, one resend before errors
      settle();
      tx_gap_pct = 0;
      rx_gap_pct = 0;
      program_regs(16'd12, 16'd25, 6'd0);
      run_phase(40, 8, 0);

      // Frequent timeouts near the limit; the response side holds off first
      settle();
      tx_gap_pct = 25;
      rx_gap_pct = 10;
      program_regs(16'd2, 16'd3, 6'd2);
      long_hold_req = 1'b1;
      run_phase(60, 40, 10);

      // Closing stretch at full rate on both sides
      settle();
      tx_gap_pct = 0;
      rx_gap_pct = 0;
      program_regs(16'd1, 16'd30, 6'd7);
      run_phase(50, 4, 5);

      settle();
      if (mismatches == 0 && results_due == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/empoll_pkg.sv
hw/rtl/empoll_front.sv
hw/rtl/empoll_fifo.sv
hw/rtl/empoll_back.sv
hw/rtl/energy_meter_poll_sequencer.sv
sim/meter_poll_checker.sv
sim/testbench.sv
